/* hw/rtl/pac_pkg.sv */
`timescale 1ns / 1ps
package pac_pkg;

    // Field and datapath widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = DIFF_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 2 * MAG_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int AREA_W  = 56;

    localparam int MAX_VERTS_DEF = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RD_FIRST,
        S_GET_FIRST,
        S_RD_NEXT,
        S_GET_NEXT,
        S_MUL,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_ACC,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    // Multiplier schedule: cross-product terms, then the squared halves
    typedef enum logic [3:0] {
        MS_KX_A, MS_KX_B,
        MS_KY_A, MS_KY_B,
        MS_KZ_A, MS_KZ_B,
        MS_XHH, MS_XHL, MS_XLL,
        MS_YHH, MS_YHL, MS_YLL,
        MS_ZHH, MS_ZHL, MS_ZLL,
        MS_DONE
    } mstep_t;

endpackage

/* hw/rtl/pac_div.sv */
`timescale 1ns / 1ps
module pac_div #(
    parameter int SUM_W = 29,
    parameter int CNT_W = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [SUM_W-1:0]           dividend,
    input  logic        [CNT_W-1:0]           divisor,
    output logic signed [pac_pkg::COORD_W-1:0] quotient,
    output logic                              done
);

    localparam int IT_W = $clog2(SUM_W);

    logic                busy_reg;
    logic                done_reg;
    logic [IT_W-1:0]     it_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    q_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    d_reg;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_diff;
    logic                fits;
    logic [SUM_W-1:0]    mag;
    logic [pac_pkg::COORD_W-1:0] q_low;

    // Take magnitude of the signed sum
    assign mag      = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    // One restoring step
    assign rem_sh   = {rem_reg, q_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign fits     = rem_sh >= {1'b0, d_reg};

    // Restore sign, truncating toward zero
    assign q_low    = q_reg[pac_pkg::COORD_W-1:0];
    assign quotient = neg_reg ? -$signed(q_low) : $signed(q_low);
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (it_reg == IT_W'(SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == IT_W'(SUM_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Advance quotient and remainder one bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            q_reg   <= mag;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

endmodule

/* hw/rtl/pac_sqrt.sv */
`timescale 1ns / 1ps
module pac_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pac_pkg::SQ_W-1:0]      radicand,
    output logic [pac_pkg::ROOT_W-1:0]    root,
    output logic                          done
);

    localparam int RW    = pac_pkg::ROOT_W;
    localparam int REM_W = RW + 2;
    localparam int IT_W  = $clog2(RW);

    logic                     busy_reg;
    logic                     done_reg;
    logic [IT_W-1:0]          it_reg;
    logic [pac_pkg::SQ_W-1:0] rad_reg;
    logic [RW-1:0]            root_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic                     fits;
    logic [REM_W+1:0]         rem_diff;

    // Bring down two radicand bits and test root*4+1
    assign rem_sh   = {rem_reg, rad_reg[pac_pkg::SQ_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign fits     = rem_sh >= trial;
    assign rem_diff = rem_sh - trial;

    assign root = root_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (it_reg == IT_W'(RW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == IT_W'(RW - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Advance one root bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[pac_pkg::SQ_W-3:0], 2'b00};
            root_reg <= {root_reg[RW-2:0], fits};
            rem_reg  <= fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        end
    end

endmodule

/* hw/rtl/polygon_area_centroid_fan.sv */
// Vertex beats load at one per cycle while the block is in its load state; in_stall is
// high otherwise. A beat with is_last=1 and no overflow then starts the barycenter
// (serial divider, one quotient bit a cycle), then per vertex a memory read, the
// multiplier products and the serial square root, then one accumulate. Overflowed
// polygons go straight to the result. Reset (rst_n low) clears counts, sums and the sequencer;
// the vertex memory is not cleared; entries past the current polygon keep older data.
`timescale 1ns / 1ps
module polygon_area_centroid_fan #(
    parameter int MAX_VERTS = pac_pkg::MAX_VERTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pac_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [pac_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [pac_pkg::COORD_W-1:0]  coord_z,
    input  logic                                is_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic        [pac_pkg::AREA_W-1:0]   area,
    output logic                                status
);

    localparam int CW     = pac_pkg::COORD_W;
    localparam int DW     = pac_pkg::DIFF_W;
    localparam int MW     = pac_pkg::MUL_W;
    localparam int PW     = pac_pkg::PROD_W;
    localparam int KW     = pac_pkg::CROSS_W;
    localparam int GW     = pac_pkg::MAG_W;
    localparam int HW     = pac_pkg::HALF_W;
    localparam int QW     = pac_pkg::SQ_W;
    localparam int RW     = pac_pkg::ROOT_W;
    localparam int AW     = pac_pkg::AREA_W;
    localparam int ADDR_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);
    localparam int SUM_W  = CW + $clog2(MAX_VERTS);

    pac_pkg::state_t state_reg, state_next;
    pac_pkg::axis_t  axis_reg;
    pac_pkg::mstep_t step_reg, tag_reg;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic                    ovf_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg, cz_reg;
    logic signed [CW-1:0]    fx_reg, fy_reg, fz_reg;
    logic signed [CW-1:0]    rx_reg, ry_reg, rz_reg;
    logic signed [DW-1:0]    ax_reg, ay_reg, az_reg;
    logic signed [DW-1:0]    bx_reg, by_reg, bz_reg;
    logic signed [KW-1:0]    kx_reg, ky_reg, kz_reg;
    logic signed [KW-1:0]    kx_next, ky_next, kz_next;
    logic [QW-1:0]           sq_reg, sq_next;
    logic signed [PW-1:0]    prod_reg;
    logic                    pvld_reg;
    logic [AW-1:0]           area_reg;
    logic                    status_reg;

    logic signed [CW-1:0] mem_x [MAX_VERTS];
    logic signed [CW-1:0] mem_y [MAX_VERTS];
    logic signed [CW-1:0] mem_z [MAX_VERTS];

    logic                 accept_in;
    logic                 room;
    logic                 mem_we;
    logic                 wrap;
    logic signed [CW-1:0] px, py, pz;
    logic signed [MW-1:0] m_a, m_b;
    logic [GW-1:0]        magx, magy, magz;
    logic                 div_start, div_done;
    logic signed [CW-1:0] div_q;
    logic signed [SUM_W-1:0] div_sum;
    logic                 sqrt_start, sqrt_done;
    logic [RW-1:0]        root;
    logic [AW:0]          area_sum;

    assign accept_in = in_valid && (state_reg == pac_pkg::S_LOAD);
    assign room      = count_reg < CNT_W'(MAX_VERTS);
    assign mem_we    = accept_in && room;
    assign wrap      = idx_reg == count_reg;
    assign in_stall  = state_reg != pac_pkg::S_LOAD;
    assign out_valid = state_reg == pac_pkg::S_OUT;
    assign area      = area_reg;
    assign status    = status_reg;

    // Store vertices; read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[count_reg[ADDR_W-1:0]] <= coord_x;
            mem_y[count_reg[ADDR_W-1:0]] <= coord_y;
            mem_z[count_reg[ADDR_W-1:0]] <= coord_z;
        end
        rx_reg <= mem_x[idx_reg[ADDR_W-1:0]];
        ry_reg <= mem_y[idx_reg[ADDR_W-1:0]];
        rz_reg <= mem_z[idx_reg[ADDR_W-1:0]];
    end

    // Serial divider for the barycenter
    always_comb
    begin
        case (axis_reg)
            pac_pkg::AX_X: div_sum = sum_x_reg;
            pac_pkg::AX_Y: div_sum = sum_y_reg;
            default:       div_sum = sum_z_reg;
        endcase
    end

    assign div_start = state_reg == pac_pkg::S_DIV_GO;

    pac_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_sum),
        .divisor  (count_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // Serial square root of the squared cross-product length
    assign sqrt_start = state_reg == pac_pkg::S_SQRT_GO;

    pac_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    // Pick the closing vertex when the index wraps
    assign px = wrap ? fx_reg : rx_reg;
    assign py = wrap ? fy_reg : ry_reg;
    assign pz = wrap ? fz_reg : rz_reg;

    // Magnitudes of the cross-product components
    assign magx = kx_reg[KW-1] ? GW'(-kx_reg) : kx_reg[GW-1:0];
    assign magy = ky_reg[KW-1] ? GW'(-ky_reg) : ky_reg[GW-1:0];
    assign magz = kz_reg[KW-1] ? GW'(-kz_reg) : kz_reg[GW-1:0];

    // Select multiplier operands by schedule step
    always_comb
    begin
        case (step_reg)
            pac_pkg::MS_KX_A: begin m_a = MW'(ay_reg); m_b = MW'(bz_reg); end
            pac_pkg::MS_KX_B: begin m_a = MW'(az_reg); m_b = MW'(by_reg); end
            pac_pkg::MS_KY_A: begin m_a = MW'(az_reg); m_b = MW'(bx_reg); end
            pac_pkg::MS_KY_B: begin m_a = MW'(ax_reg); m_b = MW'(bz_reg); end
            pac_pkg::MS_KZ_A: begin m_a = MW'(ax_reg); m_b = MW'(by_reg); end
            pac_pkg::MS_KZ_B: begin m_a = MW'(ay_reg); m_b = MW'(bx_reg); end
            pac_pkg::MS_XHH:
            begin
                m_a = {1'b0, magx[GW-1:HW]};
                m_b = {1'b0, magx[GW-1:HW]};
            end
            pac_pkg::MS_XHL:
            begin
                m_a = {1'b0, magx[GW-1:HW]};
                m_b = {1'b0, magx[HW-1:0]};
            end
            pac_pkg::MS_XLL:
            begin
                m_a = {1'b0, magx[HW-1:0]};
                m_b = {1'b0, magx[HW-1:0]};
            end
            pac_pkg::MS_YHH:
            begin
                m_a = {1'b0, magy[GW-1:HW]};
                m_b = {1'b0, magy[GW-1:HW]};
            end
            pac_pkg::MS_YHL:
            begin
                m_a = {1'b0, magy[GW-1:HW]};
                m_b = {1'b0, magy[HW-1:0]};
            end
            pac_pkg::MS_YLL:
            begin
                m_a = {1'b0, magy[HW-1:0]};
                m_b = {1'b0, magy[HW-1:0]};
            end
            pac_pkg::MS_ZHH:
            begin
                m_a = {1'b0, magz[GW-1:HW]};
                m_b = {1'b0, magz[GW-1:HW]};
            end
            pac_pkg::MS_ZHL:
            begin
                m_a = {1'b0, magz[GW-1:HW]};
                m_b = {1'b0, magz[HW-1:0]};
            end
            pac_pkg::MS_ZLL:
            begin
                m_a = {1'b0, magz[HW-1:0]};
                m_b = {1'b0, magz[HW-1:0]};
            end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    // Accumulate the registered product into its target
    always_comb
    begin
        kx_next = kx_reg;
        ky_next = ky_reg;
        kz_next = kz_reg;
        sq_next = sq_reg;
        if (pvld_reg)
        begin
            case (tag_reg)
                pac_pkg::MS_KX_A: kx_next = kx_reg + prod_reg[KW-1:0];
                pac_pkg::MS_KX_B: kx_next = kx_reg - prod_reg[KW-1:0];
                pac_pkg::MS_KY_A: ky_next = ky_reg + prod_reg[KW-1:0];
                pac_pkg::MS_KY_B: ky_next = ky_reg - prod_reg[KW-1:0];
                pac_pkg::MS_KZ_A: kz_next = kz_reg + prod_reg[KW-1:0];
                pac_pkg::MS_KZ_B: kz_next = kz_reg - prod_reg[KW-1:0];
                default:
                begin
                    if (tag_reg inside {pac_pkg::MS_XHH, pac_pkg::MS_YHH, pac_pkg::MS_ZHH})
                        sq_next = sq_reg + (QW'(prod_reg[2*HW-1:0]) << (2 * HW));
                    else if (tag_reg inside {pac_pkg::MS_XHL, pac_pkg::MS_YHL,
                                             pac_pkg::MS_ZHL})
                        sq_next = sq_reg + (QW'(prod_reg[2*HW-1:0]) << (HW + 1));
                    else
                        sq_next = sq_reg + QW'(prod_reg[2*HW-1:0]);
                end
            endcase
        end
    end

    // Saturating area sum of half the floored root
    assign area_sum = {1'b0, area_reg} + (AW + 1)'(root[RW-1:1]);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pac_pkg::S_LOAD:
            begin
                if (accept_in && is_last)
                    state_next = (ovf_reg || !room) ? pac_pkg::S_OUT : pac_pkg::S_DIV_GO;
            end
            pac_pkg::S_DIV_GO:    state_next = pac_pkg::S_DIV_WAIT;
            pac_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == pac_pkg::AX_Z) ? pac_pkg::S_RD_FIRST
                                                             : pac_pkg::S_DIV_GO;
            end
            pac_pkg::S_RD_FIRST:  state_next = pac_pkg::S_GET_FIRST;
            pac_pkg::S_GET_FIRST: state_next = pac_pkg::S_RD_NEXT;
            pac_pkg::S_RD_NEXT:   state_next = pac_pkg::S_GET_NEXT;
            pac_pkg::S_GET_NEXT:  state_next = pac_pkg::S_MUL;
            pac_pkg::S_MUL:
            begin
                if (step_reg == pac_pkg::MS_DONE)
                    state_next = pac_pkg::S_SQRT_GO;
            end
            pac_pkg::S_SQRT_GO:   state_next = pac_pkg::S_SQRT_WAIT;
            pac_pkg::S_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = pac_pkg::S_ACC;
            end
            pac_pkg::S_ACC:
            begin
                state_next = wrap ? pac_pkg::S_OUT : pac_pkg::S_RD_NEXT;
            end
            pac_pkg::S_OUT:
            begin
                if (!out_stall)
                    state_next = pac_pkg::S_LOAD;
            end
            default:              state_next = pac_pkg::S_LOAD;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pac_pkg::S_LOAD;
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            ovf_reg   <= 1'b0;
            axis_reg  <= pac_pkg::AX_X;
            idx_reg   <= '0;
            step_reg  <= pac_pkg::MS_KX_A;
            pvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                pac_pkg::S_LOAD:
                begin
                    if (mem_we)
                    begin
                        count_reg <= count_reg + 1'b1;
                        sum_x_reg <= sum_x_reg + SUM_W'(coord_x);
                        sum_y_reg <= sum_y_reg + SUM_W'(coord_y);
                        sum_z_reg <= sum_z_reg + SUM_W'(coord_z);
                    end
                    else if (accept_in)
                        ovf_reg <= 1'b1;
                    axis_reg <= pac_pkg::AX_X;
                end
                pac_pkg::S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        axis_reg <= pac_pkg::axis_t'(axis_reg + 1'b1);
                        idx_reg  <= '0;
                    end
                end
                pac_pkg::S_GET_FIRST: idx_reg <= CNT_W'(1);
                pac_pkg::S_GET_NEXT:
                begin
                    step_reg <= pac_pkg::MS_KX_A;
                    pvld_reg <= 1'b0;
                end
                pac_pkg::S_MUL:
                begin
                    pvld_reg <= step_reg != pac_pkg::MS_DONE;
                    if (step_reg != pac_pkg::MS_DONE)
                        step_reg <= pac_pkg::mstep_t'(step_reg + 1'b1);
                end
                pac_pkg::S_ACC:
                begin
                    if (!wrap)
                        idx_reg <= idx_reg + 1'b1;
                end
                pac_pkg::S_OUT:
                begin
                    if (!out_stall)
                    begin
                        count_reg <= '0;
                        sum_x_reg <= '0;
                        sum_y_reg <= '0;
                        sum_z_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pac_pkg::S_LOAD:
            begin
                area_reg   <= '0;
                status_reg <= ovf_reg || !room;
            end
            pac_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (axis_reg)
                        pac_pkg::AX_X: cx_reg <= div_q;
                        pac_pkg::AX_Y: cy_reg <= div_q;
                        default:       cz_reg <= div_q;
                    endcase
                end
            end
            pac_pkg::S_GET_FIRST:
            begin
                fx_reg <= rx_reg;
                fy_reg <= ry_reg;
                fz_reg <= rz_reg;
                ax_reg <= DW'(rx_reg) - DW'(cx_reg);
                ay_reg <= DW'(ry_reg) - DW'(cy_reg);
                az_reg <= DW'(rz_reg) - DW'(cz_reg);
            end
            pac_pkg::S_GET_NEXT:
            begin
                bx_reg <= DW'(px) - DW'(cx_reg);
                by_reg <= DW'(py) - DW'(cy_reg);
                bz_reg <= DW'(pz) - DW'(cz_reg);
                kx_reg <= '0;
                ky_reg <= '0;
                kz_reg <= '0;
                sq_reg <= '0;
            end
            pac_pkg::S_MUL:
            begin
                prod_reg <= m_a * m_b;
                tag_reg  <= step_reg;
                kx_reg   <= kx_next;
                ky_reg   <= ky_next;
                kz_reg   <= kz_next;
                sq_reg   <= sq_next;
            end
            pac_pkg::S_ACC:
            begin
                area_reg <= area_sum[AW] ? {AW{1'b1}} : area_sum[AW-1:0];
                ax_reg   <= bx_reg;
                ay_reg   <= by_reg;
                az_reg   <= bz_reg;
            end
            default: ;
        endcase
    end

endmodule

/* tb/tb_polygon_area_centroid_fan.sv */
`timescale 1ns / 1ps
module tb_polygon_area_centroid_fan;

    localparam int NVERT = pac_pkg::MAX_VERTS_DEF;
    localparam logic [55:0] AREA_MAX = {56{1'b1}};

    class area_scoreboard;
        logic signed [23:0] vx [NVERT];
        logic signed [23:0] vy [NVERT];
        logic signed [23:0] vz [NVERT];
        int unsigned count;
        logic signed [63:0] sx, sy, sz;
        bit ovf;
        logic [55:0] exp_area [$];
        bit exp_status [$];
        int errors;

        function void clear();
            count = 0;
            sx = 0;
            sy = 0;
            sz = 0;
            ovf = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function logic [55:0] tri_area(logic signed [63:0] cx, logic signed [63:0] cy,
                                       logic signed [63:0] cz, int i, int j);
            logic signed [63:0] ax, ay, az, bx, by, bz;
            logic signed [127:0] kx, ky, kz;
            logic [127:0] sq, c, r;
            ax = 64'(vx[i]) - cx;
            ay = 64'(vy[i]) - cy;
            az = 64'(vz[i]) - cz;
            bx = 64'(vx[j]) - cx;
            by = 64'(vy[j]) - cy;
            bz = 64'(vz[j]) - cz;
            kx = 128'(ay) * 128'(bz) - 128'(az) * 128'(by);
            ky = 128'(az) * 128'(bx) - 128'(ax) * 128'(bz);
            kz = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
            sq = kx * kx + ky * ky + kz * kz;
            r = 0;
            for (int b = 51; b >= 0; b--)
            begin
                c = r | (128'(1) << b);
                if (c * c <= sq)
                    r = c;
            end
            return 56'(r >> 1);
        endfunction

        // Note one accepted vertex beat; queue the polygon area on the last
        function void note_vertex(logic signed [23:0] x, logic signed [23:0] y,
                                  logic signed [23:0] z, bit last);
            logic signed [63:0] cx, cy, cz;
            logic [56:0] acc;
            if (count < NVERT)
            begin
                vx[count] = x;
                vy[count] = y;
                vz[count] = z;
                sx += x;
                sy += y;
                sz += z;
                count++;
            end
            else
                ovf = 1;
            if (!last)
                return;
            acc = 0;
            if (!ovf)
            begin
                cx = sx / $signed(64'(count));
                cy = sy / $signed(64'(count));
                cz = sz / $signed(64'(count));
                for (int i = 0; i < count; i++)
                begin
                    acc = acc + tri_area(cx, cy, cz, i, (i + 1 < count) ? i + 1 : 0);
                    if (acc > AREA_MAX)
                        acc = AREA_MAX;
                end
            end
            exp_area.push_back(acc[55:0]);
            exp_status.push_back(ovf);
            clear();
        endfunction

        task check_result(logic [55:0] a, logic s);
            logic [55:0] ea;
            bit es;
            if (exp_area.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            ea = exp_area.pop_front();
            es = exp_status.pop_front();
            if (a !== ea)
                report_mismatch($sformatf("area %0h expected %0h", a, ea));
            if (s !== es)
                report_mismatch($sformatf("status %0b expected %0b", s, es));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [23:0] coord_x = 0, coord_y = 0, coord_z = 0;
    logic is_last = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [55:0] area;
    logic status;

    area_scoreboard sb;
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    int items_sent = 0;

    polygon_area_centroid_fan dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_vertex(coord_x, coord_y, coord_z, is_last);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(area, status);
    end

    // Stall the result side in random bursts
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 17);
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
        end
    end

    function automatic logic signed [23:0] pick_coord(int mode);
        case (mode)
            0: return 24'sh800000;
            1: return 24'sh7fffff;
            2: return 0;
            3: return $signed(24'($urandom()));
            default: return $signed(24'($urandom_range(0, 16'hffff) - 16'h8000));
        endcase
    endfunction

    // Hold one beat until accepted
    task automatic send_vertex(logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] z, bit last);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 17);
            in_valid <= 0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        is_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_polygon(int nv, int mode);
        for (int i = 0; i < nv; i++)
            send_vertex(pick_coord(mode == 5 ? $urandom_range(0, 4) : mode),
                        pick_coord(mode == 5 ? $urandom_range(0, 4) : mode),
                        pick_coord(mode == 5 ? $urandom_range(0, 4) : mode),
                        i == nv - 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.exp_area.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int nv;
        sb = new();
        sb.clear();
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: single vertex, two vertices, extremes, full and overflowed
        send_polygon(1, 1);
        send_polygon(2, 3);
        send_vertex(24'sh800000, 24'sh800000, 24'sh800000, 0);
        send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh800000, 0);
        send_vertex(24'sh800000, 24'sh7fffff, 24'sh7fffff, 1);
        send_polygon(3, 2);
        send_polygon(4, 3);
        send_polygon(NVERT, 3);
        drain();
        send_polygon(NVERT + 2, 3);

        // Pause until every expected area has come
        drain();

        // Random polygons, mostly small, few at full size or overflow
        while (items_sent < 1150)
        begin
            if (items_sent > 950)
                quiet = 1;
            case ($urandom_range(0, 19))
                0: nv = NVERT;
                1: nv = NVERT + $urandom_range(1, 4);
                2: nv = $urandom_range(1, 2);
                default: nv = $urandom_range(3, 8);
            endcase
            send_polygon(nv, $urandom_range(0, 9) < 6 ? 3 : ($urandom_range(0, 1) ? 4 : 5));
        end
        drain();
        repeat (200) @(negedge clk);

        errors += sb.errors;
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/pac_pkg.sv
hw/rtl/pac_div.sv
hw/rtl/pac_sqrt.sv
hw/rtl/polygon_area_centroid_fan.sv
tb/tb_polygon_area_centroid_fan.sv
